// ----- hdl/vrfp_pkg.sv -----
// ----------------------------------------------------------------------------
// vrfp_pkg
// Shared constants and types for the video-transmitter response frame parser.
// ----------------------------------------------------------------------------
package vrfp_pkg;

  localparam int FRAME_LEN = 16;
  localparam int SUM_POS   = 14;
  localparam int CNT_W     = $clog2(FRAME_LEN);
  localparam int PAY_N     = 8;  // frame bytes 2..9 kept for decode
  localparam int PAY_IW    = $clog2(PAY_N);
  localparam int PAY_FIRST = 2;

  localparam logic [7:0] HDR_BYTE    = 8'h0F;
  localparam logic [7:0] CODE_LIMITS = 8'h72;  // 'r'
  localparam logic [7:0] CODE_STATUS = 8'h76;  // 'v'
  localparam logic [7:0] CODE_TEMP   = 8'h73;  // 's'

  localparam logic [1:0] KIND_LIMITS = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_TEMP   = 2'd2;

  typedef enum logic [2:0] {
    PH_WAIT_HDR  = 3'b001,
    PH_WAIT_CODE = 3'b010,
    PH_DATA      = 3'b100
  } phase_t;

  typedef logic [PAY_N-1:0][7:0] payload_t;

  // Frame tracker to top level
  typedef struct packed {
    logic       good;       // final byte of a frame that passed both checks
    logic [1:0] kind;       // frame kind of the current frame
    logic       last_slot;  // next byte would close a frame
  } trk_status_t;

endpackage

// ----- hdl/vrfp_frame_tracker.sv -----
// ----------------------------------------------------------------------------
// vrfp_frame_tracker
// Byte-level framing: header and code check, payload capture, running sum
// and trailer check. Flags a good frame on its last byte.
// ----------------------------------------------------------------------------
module vrfp_frame_tracker
  import vrfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  rx_byte,
  output trk_status_t status,
  output payload_t    payload
);

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [7:0]         sum, sum_next;
  logic [7:0]         sum_byte, sum_byte_next;
  logic [1:0]         kind, kind_next;
  payload_t           payload_next;
  logic               good;
  logic [CNT_W-1:0]   pay_off;

  assign pay_off = count - CNT_W'(PAY_FIRST);

  always_comb begin
    phase_next    = phase;
    count_next    = count;
    sum_next      = sum;
    sum_byte_next = sum_byte;
    kind_next     = kind;
    payload_next  = payload;
    good          = 1'b0;
    case (phase)
      PH_WAIT_CODE: begin
        if (rx_byte inside {CODE_LIMITS, CODE_STATUS, CODE_TEMP}) begin
          case (rx_byte)
            CODE_LIMITS: kind_next = KIND_LIMITS;
            CODE_STATUS: kind_next = KIND_STATUS;
            default:     kind_next = KIND_TEMP;
          endcase
          sum_next   = rx_byte;
          count_next = CNT_W'(PAY_FIRST);
          phase_next = PH_DATA;
        end else begin
          // bad code: drop frame, byte is not retried as a header
          count_next = '0;
          phase_next = PH_WAIT_HDR;
        end
      end
      PH_DATA: begin
        if (count >= CNT_W'(PAY_FIRST) && count <= CNT_W'(PAY_FIRST + PAY_N - 1)) begin
          payload_next[pay_off[PAY_IW-1:0]] = rx_byte;
        end
        if (count < CNT_W'(SUM_POS)) begin
          sum_next = sum + rx_byte;
        end else if (count == CNT_W'(SUM_POS)) begin
          sum_byte_next = rx_byte;
        end
        if (count == CNT_W'(FRAME_LEN - 1)) begin
          good       = (sum == sum_byte) && (rx_byte == 8'h00);
          count_next = '0;
          phase_next = PH_WAIT_HDR;
        end else begin
          count_next = count + 1'b1;
        end
      end
      default: begin
        if (rx_byte == HDR_BYTE) begin
          count_next = CNT_W'(1);
          phase_next = PH_WAIT_CODE;
        end else begin
          count_next = '0;
          phase_next = PH_WAIT_HDR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_WAIT_HDR;
      count    <= '0;
      sum      <= '0;
      sum_byte <= '0;
      kind     <= KIND_LIMITS;
    end else if (take) begin
      phase    <= phase_next;
      count    <= count_next;
      sum      <= sum_next;
      sum_byte <= sum_byte_next;
      kind     <= kind_next;
    end
  end

  // payload bytes are always written before a frame decodes them
  always_ff @(posedge clk) begin
    if (take) begin
      payload <= payload_next;
    end
  end

  assign status.good      = take && good;
  assign status.kind      = kind;
  assign status.last_slot = (phase == PH_DATA) && (count == CNT_W'(FRAME_LEN - 1));

endmodule

// ----- hdl/vtx_response_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// vtx_response_frame_parser_core
// Finds 16-byte response frames in a received byte stream and reports the
// kept limits, status and temperature after each good frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte): one received byte per
//   transfer. A byte is taken in each cycle with in_valid high and in_stall
//   low; the tracker registers its new state from that byte.
//   Output channel (out_valid / out_stall / result fields): one transfer per
//   good frame (header 0x0F, code r/v/s, sum of bytes 1..13 equal to byte 14,
//   byte 15 zero). Every transfer carries all kept values.
//   Result: valid in the cycle after the frame's last byte is taken.
//   Rate: one byte per cycle, except while in_stall holds off a closing byte.
//   Stall: the kept-value registers are the result register. While a result
//   waits under out_stall, bytes keep flowing; only a byte that would close
//   a frame is held off (in_stall) until the result is taken.
//   Reset (rst, synchronous): tracker back to waiting for a header, all kept
//   values and device_online cleared, no result pending.
// ----------------------------------------------------------------------------
module vtx_response_frame_parser_core
  import vrfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // received bytes
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         frame_kind,
  output logic [15:0]        freq_min,
  output logic [15:0]        freq_max,
  output logic [15:0]        power_max,
  output logic [15:0]        cur_freq,
  output logic [15:0]        config_power,
  output logic [15:0]        cur_power,
  output logic [7:0]         pit_mode,
  output logic signed [15:0] temperature,
  output logic               device_online
);

  trk_status_t trk;
  payload_t    pay;
  logic        take;

  // Hold only the closing byte of a frame while a result is still waiting.
  assign in_stall = out_valid && out_stall && trk.last_slot;
  assign take     = in_valid && !in_stall;

  vrfp_frame_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .status  (trk),
    .payload (pay)
  );

  // Result valid: set on a good frame, cleared once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (trk.good) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Kept values. Payload index 0 is frame byte 2; words are little endian.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind    <= KIND_LIMITS;
      freq_min      <= '0;
      freq_max      <= '0;
      power_max     <= '0;
      cur_freq      <= '0;
      config_power  <= '0;
      cur_power     <= '0;
      pit_mode      <= '0;
      temperature   <= '0;
      device_online <= 1'b0;
    end else if (trk.good) begin
      frame_kind <= trk.kind;
      case (trk.kind)
        KIND_LIMITS: begin
          freq_min      <= {pay[1], pay[0]};
          freq_max      <= {pay[3], pay[2]};
          power_max     <= {pay[5], pay[4]};
          device_online <= 1'b1;
        end
        KIND_STATUS: begin
          cur_freq     <= {pay[1], pay[0]};
          config_power <= {pay[3], pay[2]};
          cur_power    <= {pay[7], pay[6]};
          pit_mode     <= pay[5];
        end
        default: begin
          temperature <= {pay[5], pay[4]};  // frame bytes 6-7
        end
      endcase
    end
  end

  // A stalled result stays valid and keeps every field.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({frame_kind, freq_min, freq_max, power_max, cur_freq,
               config_power, cur_power, pit_mode, temperature, device_online}))
    else $error("stalled result changed");

  // Once online, stays online until reset.
  a_online_sticky: assert property (@(posedge clk) disable iff (rst)
    device_online |=> device_online)
    else $error("device_online dropped");

  // A limits result always reports the device online.
  a_limits_online: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind == KIND_LIMITS |-> device_online)
    else $error("limits result without device_online");

  // The input is only held off at a frame's closing byte while a result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && trk.last_slot)
    else $error("input stalled outside a pending frame close");

endmodule
